// File: sv/url_percent_decoder_top_macros.svh
// Assertion macros for the URL percent decoder checker.
// Expects clk_i and rst_ni in the scope of each use.
`ifndef URL_PERCENT_DECODER_TOP_MACROS_SVH
`define URL_PERCENT_DECODER_TOP_MACROS_SVH

// Property checked on every edge outside reset.
`define UPD_ASSERT(lbl, prop) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (prop)) \
    else $error("upd port check failed");

// Condition implies another on the following edge.
`define UPD_ASSERT_NEXT(lbl, cond, expct) \
  `UPD_ASSERT(lbl, (cond) |=> (expct))

`endif

// File: sv/upd_pkg.sv
// Shared types, constants and hex helpers for the URL percent decoder.
// No dependencies.
package upd_pkg;

  localparam logic [7:0] PCT_CHAR   = 8'h25;
  localparam logic [7:0] PLUS_CHAR  = 8'h2B;
  localparam logic [7:0] SPACE_CHAR = 8'h20;

  localparam int unsigned MAX_RES     = 3;
  localparam int unsigned QUEUE_DEPTH = 4;

  typedef struct packed {
    logic [MAX_RES-1:0][7:0] bytes;
    logic [1:0]              cnt;
    logic                    last;
  } upd_entry_t;

  function automatic logic is_hex(logic [7:0] c);
    is_hex = (c >= 8'h30 && c <= 8'h39) || (c >= 8'h41 && c <= 8'h46) ||
             (c >= 8'h61 && c <= 8'h66);
  endfunction

  function automatic logic [3:0] hex_val(logic [7:0] c);
    hex_val = (c <= 8'h39) ? c[3:0] : c[3:0] + 4'd9;
  endfunction

endpackage

// File: sv/upd_front.sv
// Front end: accepts raw bytes, tracks escape state, builds result entries.
// Depends on upd_pkg.
module upd_front
  import upd_pkg::*;
(
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       in_valid_i,
  input  logic       in_ready_i,
  input  logic [7:0] in_byte_i,
  input  logic       in_last_i,
  output logic       enq_valid_o,
  output upd_entry_t enq_data_o
);

  typedef enum logic [1:0] {PH_IDLE, PH_PCT, PH_DIGIT} phase_e;

  phase_e     phase_q, phase_d;
  logic [7:0] held_q, held_d;
  logic [7:0] idle_byte;
  logic       idle_emit;
  phase_e     idle_next;
  logic       accept;
  upd_entry_t ent;

  assign accept = in_valid_i & in_ready_i;

  always_comb begin
    idle_byte = (in_byte_i == PCT_CHAR) ? PCT_CHAR :
                ((in_byte_i == PLUS_CHAR) ? SPACE_CHAR : in_byte_i);
    idle_emit = !((in_byte_i == PCT_CHAR) && !in_last_i);
    idle_next = idle_emit ? PH_IDLE : PH_PCT;
    ent       = '0;
    ent.last  = in_last_i;
    phase_d   = idle_next;
    held_d    = '0;
    unique case (phase_q)
      PH_PCT: begin
        if (is_hex(in_byte_i)) begin
          if (in_last_i) begin
            ent.bytes[0] = PCT_CHAR;
            ent.bytes[1] = in_byte_i;
            ent.cnt      = 2'd2;
            phase_d      = PH_IDLE;
          end else begin
            phase_d = PH_DIGIT;
            held_d  = in_byte_i;
          end
        end else begin
          ent.bytes[0] = PCT_CHAR;
          ent.bytes[1] = idle_byte;
          ent.cnt      = idle_emit ? 2'd2 : 2'd1;
        end
      end
      PH_DIGIT: begin
        if (is_hex(held_q) && is_hex(in_byte_i)) begin
          ent.bytes[0] = {hex_val(held_q), hex_val(in_byte_i)};
          ent.cnt      = 2'd1;
          phase_d      = PH_IDLE;
        end else begin
          ent.bytes[0] = PCT_CHAR;
          ent.bytes[1] = held_q;
          ent.bytes[2] = idle_byte;
          ent.cnt      = idle_emit ? 2'd3 : 2'd2;
        end
      end
      default: begin
        ent.bytes[0] = idle_byte;
        ent.cnt      = idle_emit ? 2'd1 : 2'd0;
      end
    endcase
  end

  assign enq_valid_o = accept && (ent.cnt != 2'd0);
  assign enq_data_o  = ent;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q <= PH_IDLE;
      held_q  <= '0;
    end else if (accept) begin
      phase_q <= phase_d;
      held_q  <= held_d;
    end
  end

endmodule

// File: sv/upd_queue.sv
// Short FIFO of result entries between front and back.
// Depends on upd_pkg.
module upd_queue
  import upd_pkg::*;
#(
  parameter int unsigned QDepth = QUEUE_DEPTH
) (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       push_i,
  input  upd_entry_t push_data_i,
  input  logic       pop_i,
  output logic       full_o,
  output logic       valid_o,
  output upd_entry_t head_o
);

  localparam int unsigned PtrW = (QDepth > 1) ? $clog2(QDepth) : 1;
  localparam int unsigned CntW = $clog2(QDepth + 1);

  upd_entry_t            mem_q [QDepth];
  logic [PtrW-1:0]       wr_ptr_q, rd_ptr_q;
  logic [CntW-1:0]       cnt_q;
  logic                  do_push, do_pop;

  assign full_o  = (cnt_q == CntW'(QDepth));
  assign valid_o = (cnt_q != '0);
  assign head_o  = mem_q[rd_ptr_q];
  assign do_push = push_i & !full_o;
  assign do_pop  = pop_i & valid_o;

  always_ff @(posedge clk_i) begin
    if (do_push) begin
      mem_q[wr_ptr_q] <= push_data_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      cnt_q    <= '0;
    end else begin
      if (do_push) begin
        wr_ptr_q <= (wr_ptr_q == PtrW'(QDepth - 1)) ? '0 : wr_ptr_q + 1'b1;
      end
      if (do_pop) begin
        rd_ptr_q <= (rd_ptr_q == PtrW'(QDepth - 1)) ? '0 : rd_ptr_q + 1'b1;
      end
      if (do_push && !do_pop) begin
        cnt_q <= cnt_q + 1'b1;
      end else if (do_pop && !do_push) begin
        cnt_q <= cnt_q - 1'b1;
      end
    end
  end

endmodule

// File: sv/upd_back.sv
// Back end: walks the head entry one byte per transfer into an output register.
// Depends on upd_pkg.
module upd_back
  import upd_pkg::*;
(
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       head_valid_i,
  input  upd_entry_t head_i,
  output logic       pop_o,
  output logic       out_valid_o,
  input  logic       out_ready_i,
  output logic [7:0] out_byte_o,
  output logic       run_last_o,
  output logic       string_end_o
);

  logic [1:0] idx_q;
  logic       valid_q;
  logic [7:0] byte_q;
  logic       run_last_q, string_end_q;
  logic       load, fin;

  assign load  = head_valid_i && (!valid_q || out_ready_i);
  assign fin   = (idx_q == head_i.cnt - 2'd1);
  assign pop_o = load && fin;

  assign out_valid_o  = valid_q;
  assign out_byte_o   = byte_q;
  assign run_last_o   = run_last_q;
  assign string_end_o = string_end_q;

  always_ff @(posedge clk_i) begin
    if (load) begin
      byte_q       <= head_i.bytes[idx_q];
      run_last_q   <= fin;
      string_end_q <= fin && head_i.last;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      idx_q   <= '0;
      valid_q <= 1'b0;
    end else if (load) begin
      idx_q   <= fin ? 2'd0 : idx_q + 2'd1;
      valid_q <= 1'b1;
    end else if (out_ready_i) begin
      valid_q <= 1'b0;
    end
  end

endmodule

// File: sv/url_percent_decoder_top.sv
// Top level of the URL percent decoder (form-urlencoded).
// Depends on upd_pkg, upd_front, upd_queue, upd_back.
//
//  channel   dir  tdata          tlast      tuser
//  s_axis    in   in_byte[7:0]   in_last    -
//  m_axis    out  out_byte[7:0]  run_last   string_end
//
// One input byte is taken per cycle while the entry queue has room.
// Each decoded byte is one output transfer; a broken escape or a flush
// yields one to three bytes, so that item holds the output register for as many transfers.
// The queue holds QDepth entries and lets either side stall alone.
// rst_ni clears escape state, queue pointers and the output valid.
module url_percent_decoder_top
  import upd_pkg::*;
#(
  parameter int unsigned QDepth = QUEUE_DEPTH
) (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       s_axis_tvalid,
  output logic       s_axis_tready,
  input  logic [7:0] s_axis_tdata,   // [7:0] in_byte
  input  logic       s_axis_tlast,
  output logic       m_axis_tvalid,
  input  logic       m_axis_tready,
  output logic [7:0] m_axis_tdata,   // [7:0] out_byte
  output logic       m_axis_tlast,
  output logic       m_axis_tuser    // [0] string_end
);

  logic       enq_valid, q_full, q_valid, pop;
  upd_entry_t enq_data, head;

  assign s_axis_tready = !q_full;

  upd_front u_front (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (s_axis_tvalid),
    .in_ready_i  (s_axis_tready),
    .in_byte_i   (s_axis_tdata),
    .in_last_i   (s_axis_tlast),
    .enq_valid_o (enq_valid),
    .enq_data_o  (enq_data)
  );

  upd_queue #(.QDepth(QDepth)) u_queue (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .push_i      (enq_valid),
    .push_data_i (enq_data),
    .pop_i       (pop),
    .full_o      (q_full),
    .valid_o     (q_valid),
    .head_o      (head)
  );

  upd_back u_back (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .head_valid_i (q_valid),
    .head_i       (head),
    .pop_o        (pop),
    .out_valid_o  (m_axis_tvalid),
    .out_ready_i  (m_axis_tready),
    .out_byte_o   (m_axis_tdata),
    .run_last_o   (m_axis_tlast),
    .string_end_o (m_axis_tuser)
  );

endmodule

// File: sv/upd_port_chk.sv
// Port-level checks for url_percent_decoder_top, bound to the top level.
// Depends on url_percent_decoder_top_macros.svh.
`include "url_percent_decoder_top_macros.svh"

module upd_port_chk (
  input logic       clk_i,
  input logic       rst_ni,
  input logic       s_axis_tready,
  input logic       m_axis_tvalid,
  input logic       m_axis_tready,
  input logic [7:0] m_axis_tdata,
  input logic       m_axis_tlast,
  input logic       m_axis_tuser
);

  `UPD_ASSERT_NEXT(a_out_hold, m_axis_tvalid && !m_axis_tready,
                   m_axis_tvalid && $stable({m_axis_tdata, m_axis_tlast, m_axis_tuser}))
  `UPD_ASSERT(a_end_is_run_last, m_axis_tvalid && m_axis_tuser |-> m_axis_tlast)
  `UPD_ASSERT(a_full_has_output, !s_axis_tready |-> m_axis_tvalid)

endmodule

bind url_percent_decoder_top upd_port_chk u_port_chk (.*);

// File: sim/tb_top.sv
// Self-checking testbench for url_percent_decoder_top: directed and random encoded
// strings go in over s_axis, and a scoreboard predicts and compares the decoded bytes.
// Depends on upd_pkg and url_percent_decoder_top.
module tb_top;
  timeunit 1ns;
  timeprecision 1ps;

  import upd_pkg::*;

  localparam int unsigned CycleLimit  = 400000;
  localparam int unsigned TargetItems = 415;
  localparam int unsigned DrainCycles = 20;

  typedef enum logic [1:0] {PH_IDLE, PH_PCT, PH_DIGIT} esc_phase_e;

  typedef struct packed {
    logic [7:0] out_byte;
    logic       run_last;
    logic       string_end;
  } dec_result_t;

  typedef logic [7:0] byte_q_t[$];

  class decode_scoreboard;
    esc_phase_e  phase;
    logic [7:0]  held;
    dec_result_t pending_q[$];
    logic [7:0]  emit_q[$];
    int          errors;
    int          checked;
    int          escapes;

    function new();
      phase   = PH_IDLE;
      held    = '0;
      errors  = 0;
      checked = 0;
      escapes = 0;
    endfunction

    function int nibble(logic [7:0] c);
      if (c >= "0" && c <= "9") return int'(c) - int'("0");
      if (c >= "A" && c <= "F") return int'(c) - int'("A") + 10;
      if (c >= "a" && c <= "f") return int'(c) - int'("a") + 10;
      return -1;
    endfunction

    function void add_emit(logic [7:0] b);
      emit_q = {emit_q, b};
    endfunction

    function esc_phase_e from_idle(logic [7:0] b, logic l);
      if (b == PCT_CHAR) begin
        if (l) begin
          add_emit(PCT_CHAR);
          return PH_IDLE;
        end
        return PH_PCT;
      end
      add_emit((b == PLUS_CHAR) ? SPACE_CHAR : b);
      return PH_IDLE;
    endfunction

    function void note_input(logic [7:0] b, logic l);
      esc_phase_e  nxt;
      int          hi;
      int          lo;
      dec_result_t r;
      emit_q.delete();
      hi = nibble(held);
      lo = nibble(b);
      case (phase)
        PH_PCT: begin
          if (lo >= 0) begin
            if (l) begin
              add_emit(PCT_CHAR);
              add_emit(b);
              nxt = PH_IDLE;
            end else begin
              held = b;
              nxt  = PH_DIGIT;
            end
          end else begin
            add_emit(PCT_CHAR);
            nxt = from_idle(b, l);
          end
        end
        PH_DIGIT: begin
          if (hi >= 0 && lo >= 0) begin
            add_emit(8'((hi << 4) | lo));
            escapes++;
            nxt = PH_IDLE;
          end else begin
            add_emit(PCT_CHAR);
            add_emit(held);
            nxt = from_idle(b, l);
          end
        end
        default: nxt = from_idle(b, l);
      endcase
      if (l || nxt != PH_DIGIT) held = '0;
      phase = l ? PH_IDLE : nxt;
      foreach (emit_q[i]) begin
        r.out_byte   = emit_q[i];
        r.run_last   = (i == emit_q.size() - 1);
        r.string_end = r.run_last && l;
        pending_q    = {pending_q, r};
      end
    endfunction

    function void check_output(logic [7:0] d, logic t, logic u);
      dec_result_t e;
      if (pending_q.size() == 0) begin
        $error("unexpected transfer: out_byte %02h run_last %0b string_end %0b", d, t, u);
        errors++;
        return;
      end
      e = pending_q.pop_front();
      checked++;
      if (e.out_byte != d) begin
        $error("out_byte: expected %02h, actual %02h", e.out_byte, d);
        errors++;
      end
      if (e.run_last != t) begin
        $error("run_last: expected %0b, actual %0b", e.run_last, t);
        errors++;
      end
      if (e.string_end != u) begin
        $error("string_end: expected %0b, actual %0b", e.string_end, u);
        errors++;
      end
    endfunction

    function void close();
      if (pending_q.size() != 0) begin
        $error("%0d decoded bytes never arrived", pending_q.size());
        errors++;
      end
    endfunction
  endclass

  logic       clk_i = 1'b0;
  logic       rst_ni = 1'b0;
  logic       s_axis_tvalid = 1'b0;
  logic       s_axis_tready;
  logic [7:0] s_axis_tdata = '0;   // [7:0] in_byte
  logic       s_axis_tlast = 1'b0;
  logic       m_axis_tvalid;
  logic       m_axis_tready = 1'b0;
  logic [7:0] m_axis_tdata;        // [7:0] out_byte
  logic       m_axis_tlast;
  logic       m_axis_tuser;        // [0] string_end

  decode_scoreboard sb;
  int unsigned      cycles = 0;
  int               items_sent = 0;
  int               strings_sent = 0;
  int               rx_hold = 0;
  int               rx_wait = 0;
  bit               calm = 1'b0;

  url_percent_decoder_top dut (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tlast  (s_axis_tlast),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tlast  (m_axis_tlast),
    .m_axis_tuser  (m_axis_tuser)
  );

  always #5 clk_i = ~clk_i;

  function automatic int idle_len();
    int r;
    if (calm) return 0;
    r = $urandom_range(0, 99);
    if (r < 60) return 0;
    if (r < 90) return $urandom_range(1, 3);
    if (r < 98) return $urandom_range(4, 10);
    return $urandom_range(20, 60);
  endfunction

  function automatic logic [7:0] pick_hex();
    int r;
    r = $urandom_range(0, 21);
    if (r < 10) return 8'("0" + r);
    if (r < 16) return 8'("A" + r - 10);
    return 8'("a" + r - 16);
  endfunction

  function automatic logic [7:0] pick_non_hex();
    logic [7:0] c;
    do c = 8'($urandom_range(0, 255)); while (sb.nibble(c) >= 0);
    return c;
  endfunction

  task automatic send_bytes(input byte_q_t data_q);
    int gap;
    for (int i = 0; i < data_q.size(); i++) begin
      s_axis_tdata  <= data_q[i];
      s_axis_tlast  <= (i == data_q.size() - 1);
      s_axis_tvalid <= 1'b1;
      do @(posedge clk_i); while (!s_axis_tready);
      sb.note_input(data_q[i], i == data_q.size() - 1);
      items_sent++;
      gap = idle_len();
      if (gap > 0) begin
        s_axis_tvalid <= 1'b0;
        repeat (gap) @(posedge clk_i);
      end
    end
    strings_sent++;
  endtask

  task automatic send_text(input string s);
    byte_q_t q;
    for (int i = 0; i < s.len(); i++) q = {q, 8'(s[i])};
    send_bytes(q);
  endtask

  task automatic drain_results();
    s_axis_tvalid <= 1'b0;
    while (sb.pending_q.size() != 0) @(posedge clk_i);
  endtask

  task automatic send_random_string();
    byte_q_t q;
    int      len;
    int      r;
    len = ($urandom_range(0, 9) == 0) ? $urandom_range(9, 20) : $urandom_range(1, 8);
    while (q.size() < len) begin
      r = $urandom_range(0, 99);
      if (r < 40) begin
        q = {q, PCT_CHAR};
        q = {q, pick_hex()};
        q = {q, pick_hex()};
      end else if (r < 50) begin
        q = {q, PLUS_CHAR};
      end else if (r < 60) begin
        q = {q, PCT_CHAR};
        case ($urandom_range(0, 3))
          0: q = {q, pick_non_hex()};
          1: begin
            q = {q, pick_hex()};
            q = {q, pick_non_hex()};
          end
          2: begin
            q = {q, pick_hex()};
            q = {q, PCT_CHAR};
          end
          default: q = {q, PLUS_CHAR};
        endcase
      end else begin
        q = {q, 8'($urandom_range(0, 255))};
      end
    end
    while (q.size() > len) void'(q.pop_back());
    calm = ($urandom_range(0, 9) == 0);
    send_bytes(q);
    calm = 1'b0;
  endtask

  initial begin
    forever begin
      @(posedge clk_i);
      if (rst_ni && m_axis_tvalid && m_axis_tready) begin
        sb.check_output(m_axis_tdata, m_axis_tlast, m_axis_tuser);
      end
      if (rx_hold > 0) begin
        rx_hold--;
        m_axis_tready <= 1'b0;
      end else if (rx_wait > 0) begin
        rx_wait--;
        m_axis_tready <= 1'b0;
      end else begin
        m_axis_tready <= 1'b1;
        rx_wait = idle_len();
      end
    end
  end

  initial begin
    forever begin
      @(posedge clk_i);
      cycles++;
      if (cycles > CycleLimit) begin
        $display("tb_top failed");
        $finish;
      end
    end
  end

  initial begin
    byte_q_t edge_q;
    bit      held_off;
    bit      paused;
    held_off = 1'b0;
    paused   = 1'b0;
    sb = new();
    repeat (3) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    send_text("%41");
    send_text("%6a%Fc");
    send_text("a+b");
    send_text("%");
    send_text("%4");
    send_text("%4G");
    send_text("%%41");
    send_text("%+x");
    send_text("%4+");
    send_text("%4%");
    edge_q = '{8'h00, 8'hFF};
    send_bytes(edge_q);
    drain_results();

    while (items_sent < TargetItems) begin
      if (!held_off && items_sent >= 150) begin
        rx_hold  = 300;
        held_off = 1'b1;
      end
      if (!paused && items_sent >= 300) begin
        drain_results();
        repeat (DrainCycles) @(posedge clk_i);
        paused = 1'b1;
      end
      send_random_string();
    end

    drain_results();
    repeat (DrainCycles) @(posedge clk_i);
    sb.close();
    $display("Summary: %0d encoded bytes in %0d strings, %0d decoded bytes checked,",
             items_sent, strings_sent, sb.checked);
    $display("  %0d hex escapes decoded, with one long output stall and one full drain pause",
             sb.escapes);
    if (sb.errors == 0) begin
      $display("tb_top passed");
    end else begin
      $display("tb_top failed");
    end
    $finish;
  end
endmodule
